// ----- design/min_tracking_stack_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the min tracking stack
// Clocked property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_CORE_ASSERT_SVH
`define MIN_TRACKING_STACK_CORE_ASSERT_SVH

// checked only outside reset
`define MTS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("min tracking stack check failed");

// checked at every edge, reset included
`define MTS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("min tracking stack reset check failed");

`endif

// ----- design/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants and codes for the min tracking stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mts_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed port widths
    localparam int DATA_W      = 32;
    localparam int DEPTH_OUT_W = 8;
    localparam int STATUS_W    = 2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_OVERFLOW = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;

endpackage

// ----- design/mts_ram.sv -----
// ----------------------------------------------------------------------------
// mts_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/min_tracking_stack_core.sv -----
// ----------------------------------------------------------------------------
// min_tracking_stack_core
// Stack of signed values that reports its minimum along with every result.
// ----------------------------------------------------------------------------
// Each transfer in is a push or a pop and yields one transfer out. A push
// result is registered from S_IDLE; a pop first passes through S_RD, as
// the new top of the value stack and, when the minimum leaves, the new top
// of the minimum stack come out of synchronous RAMs with registered read
// data. The current top and minimum are kept in registers, so pushes never
// read memory. A finished result waits in an output register; the next
// item is taken in the same cycle that result is transferred out.
`timescale 1ns / 1ps

module min_tracking_stack_core
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_opcode,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_status                 o_status,
    output logic signed [DATA_W-1:0] o_popped_value,
    output logic                    o_top_valid,
    output logic signed [DATA_W-1:0] o_top_value,
    output logic signed [DATA_W-1:0] o_min_value,
    output logic [DEPTH_OUT_W-1:0]  o_depth_now
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int VW = VALUE_WIDTH;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RD   = 1'b1;

    logic                    r_state;
    logic [CW-1:0]           r_cnt;
    logic [CW-1:0]           r_mcnt;
    logic signed [VW-1:0]    r_top;
    logic signed [VW-1:0]    r_min;
    logic                    r_mpop;

    logic                    r_out_valid;
    logic                    n_out_valid;
    t_status                 r_status;
    logic signed [DATA_W-1:0] r_popped;
    logic                    r_top_valid;
    logic signed [DATA_W-1:0] r_top_value;
    logic signed [DATA_W-1:0] r_min_value;
    logic [DEPTH_OUT_W-1:0]  r_depth;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_push_ok;
    logic                    w_pop_ok;
    logic                    w_min_take;
    logic signed [VW-1:0]    w_val;
    logic [VW-1:0]           w_vrd_raw;
    logic [VW-1:0]           w_mrd_raw;
    logic signed [VW-1:0]    w_vrd;
    logic signed [VW-1:0]    w_new_min;
    logic signed [DATA_W-1:0] w_val32;
    logic signed [DATA_W-1:0] w_top32;
    logic signed [DATA_W-1:0] w_min32;
    logic signed [DATA_W-1:0] w_vrd32;
    logic signed [DATA_W-1:0] w_new_min32;
    logic [CW-1:0]           w_cnt_inc;
    logic [CW-1:0]           w_cnt_dec;
    logic [CW-1:0]           w_mcnt_dec;
    logic [AW-1:0]           w_vraddr;
    logic [AW-1:0]           w_mraddr;

    // input is the low bits of the 32-bit field, zero-extended if wider
    assign w_val   = VW'($unsigned(i_push_value));
    assign w_val32 = DATA_W'(w_val);
    assign w_top32 = DATA_W'(r_top);
    assign w_min32 = DATA_W'(r_min);

    assign w_vrd       = w_vrd_raw;
    assign w_new_min   = r_mpop ? signed'(w_mrd_raw) : r_min;
    assign w_vrd32     = DATA_W'(w_vrd);
    assign w_new_min32 = DATA_W'(w_new_min);

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_cnt == CW'(STACK_DEPTH));
    assign w_empty    = (r_cnt == '0);
    assign w_push_ok  = w_accept && (i_opcode == OP_PUSH) && !w_full;
    assign w_pop_ok   = w_accept && (i_opcode == OP_POP) && !w_empty;
    assign w_min_take = (r_mcnt == '0) ||
                        ((r_mcnt < CW'(STACK_DEPTH)) && (w_val <= r_min));

    assign w_cnt_inc  = r_cnt + CW'(1);
    assign w_cnt_dec  = r_cnt - CW'(1);
    assign w_mcnt_dec = r_mcnt - CW'(1);
    // entry below the current top becomes the new top after a pop
    assign w_vraddr   = AW'(r_cnt - CW'(2));
    assign w_mraddr   = AW'(r_mcnt - CW'(2));

    // result goes valid when an item completes, clears on its transfer
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if ((r_state == S_RD) || (w_accept && !w_pop_ok)) begin
            n_out_valid = 1'b1;
        end
    end

    mts_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (VW),
        .AW    (AW)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_push_ok),
        .i_waddr (AW'(r_cnt)),
        .i_wdata (w_val),
        .i_re    (w_pop_ok),
        .i_raddr (w_vraddr),
        .o_rdata (w_vrd_raw)
    );

    mts_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (VW),
        .AW    (AW)
    ) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (w_push_ok && w_min_take),
        .i_waddr (AW'(r_mcnt)),
        .i_wdata (w_val),
        .i_re    (w_pop_ok),
        .i_raddr (w_mraddr),
        .o_rdata (w_mrd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_mcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_opcode == OP_PUSH) begin
                            if (w_full) begin
                                r_status    <= ST_OVERFLOW;
                                r_popped    <= '0;
                                r_top_valid <= !w_empty;
                                r_top_value <= w_empty ? '0 : w_top32;
                                r_min_value <= (!w_empty && r_mcnt != '0) ? w_min32 : '0;
                                r_depth     <= DEPTH_OUT_W'(r_cnt);
                            end else begin
                                r_status    <= ST_OK;
                                r_popped    <= '0;
                                r_cnt       <= w_cnt_inc;
                                r_top       <= w_val;
                                r_top_valid <= 1'b1;
                                r_top_value <= w_val32;
                                r_depth     <= DEPTH_OUT_W'(w_cnt_inc);
                                if (w_min_take) begin
                                    r_mcnt      <= r_mcnt + CW'(1);
                                    r_min       <= w_val;
                                    r_min_value <= w_val32;
                                end else begin
                                    r_min_value <= w_min32;
                                end
                            end
                        end else begin
                            if (w_empty) begin
                                r_status    <= ST_EMPTY;
                                r_popped    <= '0;
                                r_top_valid <= 1'b0;
                                r_top_value <= '0;
                                r_min_value <= '0;
                                r_depth     <= '0;
                            end else begin
                                // result completes once the RAM reads return
                                r_status <= ST_OK;
                                r_popped <= w_top32;
                                r_cnt    <= w_cnt_dec;
                                r_mpop   <= (r_mcnt != '0) && (r_top == r_min);
                                if ((r_mcnt != '0) && (r_top == r_min)) begin
                                    r_mcnt <= w_mcnt_dec;
                                end
                                r_state  <= S_RD;
                            end
                        end
                    end
                end
                S_RD: begin
                    r_top       <= w_vrd;
                    r_min       <= w_new_min;
                    r_top_valid <= (r_cnt != '0);
                    r_top_value <= (r_cnt != '0) ? w_vrd32 : '0;
                    r_min_value <= (r_cnt != '0 && r_mcnt != '0) ? w_new_min32 : '0;
                    r_depth     <= DEPTH_OUT_W'(r_cnt);
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign o_top_valid    = r_top_valid;
    assign o_top_value    = r_top_value;
    assign o_min_value    = r_min_value;
    assign o_depth_now    = r_depth;

endmodule

// ----- design/mts_checker.sv -----
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks on the min tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_tracking_stack_core_assert.svh"

module mts_checker
    import mts_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     i_opcode,
    input logic signed [DATA_W-1:0] i_push_value,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input t_status                  o_status,
    input logic signed [DATA_W-1:0] o_popped_value,
    input logic                     o_top_valid,
    input logic signed [DATA_W-1:0] o_top_value,
    input logic signed [DATA_W-1:0] o_min_value,
    input logic [DEPTH_OUT_W-1:0]   o_depth_now
);

    // a stalled result holds
    `MTS_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) && $stable(o_top_value) && $stable(o_min_value))

    // a refused pop leaves an empty stack and pops nothing
    `MTS_ASSERT(a_empty_pop, o_out_valid && o_status == ST_EMPTY |-> !o_top_valid && o_depth_now == '0 && o_popped_value == '0)

    // an empty stack shows zero top and minimum
    `MTS_ASSERT(a_empty_zero, o_out_valid && !o_top_valid |-> o_top_value == '0 && o_min_value == '0 && o_depth_now == '0)

    // overflow only happens on a nonempty stack
    `MTS_ASSERT(a_overflow, o_out_valid && o_status == ST_OVERFLOW |-> o_top_valid && o_popped_value == '0)

    `MTS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid)

endmodule

bind min_tracking_stack_core mts_checker u_mts_checker (.*);

// ----- bench/min_tracking_stack_core_test.sv -----
// ----------------------------------------------------------------------------
// min_tracking_stack_core_test
// Self-checking bench: pushes and pops with checked top, minimum and depth.
// ----------------------------------------------------------------------------
// Each accepted operation updates a software copy of the value stack and
// the minimum stack. The expected result goes into a queue, and every
// result transfer is compared field by field with the oldest entry.
// Stimulus starts with a short directed sequence (extreme values, duplicate
// minimums, pop on empty). Random walks follow, along with full fill and
// drain runs that hit the overflow and empty refusals. The run has three
// idle profiles, and one long output stall backs up the input.
`timescale 1ns / 1ps

module min_tracking_stack_core_test;
    import mts_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 277;
    localparam int HOLD_CYCLES  = 150;
    localparam int SIGNED_MAX   = 32'sh7fff_ffff;
    localparam int SIGNED_MIN   = 32'sh8000_0000;

    typedef struct {
        t_status                 status;
        logic signed [DATA_W-1:0] popped;
        logic                    top_valid;
        logic signed [DATA_W-1:0] top;
        logic signed [DATA_W-1:0] min_val;
        logic [DEPTH_OUT_W-1:0]  depth;
    } t_stack_result;

    class min_stack_scoreboard;
        int            value_mem[STACK_DEPTH_DEF];
        int            min_mem[STACK_DEPTH_DEF];
        int            value_count;
        int            min_count;
        t_stack_result pending_results[$];
        int            errors;
        int            checked;
        int            n_push_ok;
        int            n_pop_ok;
        int            n_overflow;
        int            n_empty;
        int            peak_depth;

        function new();
            value_count = 0;
            min_count   = 0;
            errors      = 0;
            checked     = 0;
            n_push_ok   = 0;
            n_pop_ok    = 0;
            n_overflow  = 0;
            n_empty     = 0;
            peak_depth  = 0;
        endfunction

        function int depth();
            return value_count;
        endfunction

        function int min_top();
            return (min_count > 0) ? min_mem[min_count-1] : 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // apply one accepted operation and queue the result it must produce
        function void predict_op(logic op, int value);
            t_stack_result r;
            r.status = ST_OK;
            r.popped = '0;
            if (op == OP_PUSH) begin
                if (value_count >= STACK_DEPTH_DEF) begin
                    r.status = ST_OVERFLOW;
                    n_overflow++;
                end else begin
                    value_mem[value_count] = value;
                    value_count++;
                    if (min_count == 0) begin
                        min_mem[0] = value;
                        min_count  = 1;
                    end else if (min_count < STACK_DEPTH_DEF &&
                                 value <= min_mem[min_count-1]) begin
                        min_mem[min_count] = value;
                        min_count++;
                    end
                    n_push_ok++;
                    if (value_count > peak_depth) peak_depth = value_count;
                end
            end else begin
                if (value_count == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    value_count--;
                    r.popped = value_mem[value_count];
                    // min stack drops its top only when that exact value leaves
                    if (min_count > 0 && value_mem[value_count] == min_mem[min_count-1])
                        min_count--;
                    n_pop_ok++;
                end
            end
            r.top_valid = (value_count > 0);
            r.top       = (value_count > 0) ? value_mem[value_count-1] : 0;
            r.min_val   = (value_count > 0 && min_count > 0) ? min_mem[min_count-1] : 0;
            r.depth     = DEPTH_OUT_W'(value_count);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] seen);
            if (seen !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name,
                       $signed(want), $signed(seen));
                errors++;
            end
        endfunction

        function void check_result(t_stack_result got);
            t_stack_result want;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing outstanding");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("status",       DATA_W'(want.status),    DATA_W'(got.status));
            compare_field("popped_value", want.popped,             got.popped);
            compare_field("top_valid",    DATA_W'(want.top_valid), DATA_W'(got.top_valid));
            compare_field("top_value",    want.top,                got.top);
            compare_field("min_value",    want.min_val,            got.min_val);
            compare_field("depth_now",    DATA_W'(want.depth),     DATA_W'(got.depth));
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic                     i_opcode;
    logic signed [DATA_W-1:0] i_push_value;
    logic                     o_out_valid;
    logic                     i_out_ready;
    t_status                  o_status;
    logic signed [DATA_W-1:0] o_popped_value;
    logic                     o_top_valid;
    logic signed [DATA_W-1:0] o_top_value;
    logic signed [DATA_W-1:0] o_min_value;
    logic [DEPTH_OUT_W-1:0]   o_depth_now;

    min_stack_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int items_sent;
    int stall_count;

    min_tracking_stack_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_push_value   (i_push_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_top_valid    (o_top_valid),
        .o_top_value    (o_top_value),
        .o_min_value    (o_min_value),
        .o_depth_now    (o_depth_now)
    );

    always #10 i_clk = ~i_clk;

    // result side: random back-pressure, plus one long hold when requested
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_stack_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.status    = o_status;
            got.popped    = o_popped_value;
            got.top_valid = o_top_valid;
            got.top       = o_top_value;
            got.min_val   = o_min_value;
            got.depth     = o_depth_now;
            sb.check_result(got);
        end
    end

    // watchdog: cycles without any transfer on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_op(input logic op, input int value);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_push_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        sb.predict_op(op, value);
        items_sent++;
    endtask

    // small values make ties with the current minimum common
    function automatic int pick_value();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return SIGNED_MAX;
                    1: return SIGNED_MIN;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            1, 2: return $urandom;
            3: return sb.min_top();
            default: return $urandom_range(20) - 10;
        endcase
    endfunction

    task automatic send_pop();
        send_op(OP_POP, $urandom);
    endtask

    task automatic fill_stack();
        while (sb.depth() < STACK_DEPTH_DEF) send_op(OP_PUSH, pick_value());
        repeat ($urandom_range(1, 3)) send_op(OP_PUSH, pick_value());
    endtask

    task automatic drain_stack();
        while (sb.depth() > 0) send_pop();
        repeat ($urandom_range(1, 2)) send_pop();
    endtask

    task automatic run_phase(input int n_items);
        int start;
        int kind;
        int push_pct;
        start = items_sent;
        while (items_sent - start < n_items) begin
            kind = $urandom_range(19);
            if (kind == 0) begin
                fill_stack();
            end else if (kind == 1) begin
                drain_stack();
            end else begin
                case ($urandom_range(2))
                    0: push_pct = 80;
                    1: push_pct = 50;
                    default: push_pct = 25;
                endcase
                repeat ($urandom_range(10, 40)) begin
                    if ($urandom_range(99) < push_pct)
                        send_op(OP_PUSH, pick_value());
                    else
                        send_pop();
                end
            end
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_PUSH;
        i_push_value = '0;
        i_out_ready  = 1'b0;
        hold_left    = 0;
        items_sent   = 0;
        stall_count  = 0;
        sb = new();
        send_idle_pct = 14;
        recv_idle_pct = 64;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pop, extremes, duplicate minimums, min restore
        send_pop();
        send_op(OP_PUSH, 0);
        send_op(OP_PUSH, SIGNED_MAX);
        send_op(OP_PUSH, SIGNED_MIN);
        send_op(OP_PUSH, SIGNED_MIN);
        send_op(OP_PUSH, -1);
        send_op(OP_PUSH, SIGNED_MAX);
        repeat (5) send_pop();
        send_op(OP_PUSH, 5);
        send_op(OP_PUSH, 5);
        send_op(OP_PUSH, 3);
        repeat (5) send_pop();

        // every phase runs the full depth at least once
        fill_stack();
        drain_stack();
        run_phase(PHASE_ITEMS - 2 * STACK_DEPTH_DEF);

        send_idle_pct = 64;
        recv_idle_pct = 14;
        fill_stack();
        run_phase(PHASE_ITEMS - 2 * STACK_DEPTH_DEF);
        drain_stack();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = HOLD_CYCLES;
        fill_stack();
        drain_stack();
        run_phase(PHASE_ITEMS - 2 * STACK_DEPTH_DEF);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d operations: %0d pushes, %0d pops, %0d overflow, %0d empty",
                 items_sent, sb.n_push_ok, sb.n_pop_ok, sb.n_overflow, sb.n_empty);
        $display("Checked %0d results, peak depth %0d, %0d mismatches",
                 sb.checked, sb.peak_depth, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
